/* design/chmb_pkg.sv */
// Package for the color histogram model / back-projection block.
// Holds command codes, config register indices and fixed constants.
package chmb_pkg;

  typedef enum logic [1:0] {
    CMD_LEARN  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_BPROJ  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam int unsigned REG_COLOR_MODE  = 0;
  localparam int unsigned REG_INSIDE_MODE = 1;
  localparam int unsigned REG_RECT_LEFT   = 2;
  localparam int unsigned REG_RECT_TOP    = 3;
  localparam int unsigned REG_RECT_RIGHT  = 4;
  localparam int unsigned REG_RECT_BOTTOM = 5;
  localparam int unsigned REG_BASE_RATE   = 6;
  localparam int unsigned REG_RATE_RATIO  = 7;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 31;
  localparam int unsigned BIN_VAL_BITS  = 32;
  localparam int unsigned Q8_ONE        = 256;
  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;

endpackage

/* design/color_histogram_model_backproject_top.sv */
// Channel    | handshake      | payload
// input      | push / full    | cmd pos_x pos_y chan_a chan_b chan_c
// result     | empty / pop    | likelihood commit_done
// config     | cfg_we         | cfg_index cfg_data
// A learn or back-project pixel passes the S_RD and S_WR states in the back part, bounded by
// the frame RAM read-modify-write; a 4-entry queue absorbs bursts.
// A commit sweeps all 2**(3*(8-BIN_SHIFT)) bins, one per cycle.
// A commit or back-project waits in the queue while a result is unread.
// After reset a clearing pass over all 2**(3*(8-BIN_SHIFT)) bins holds full high.
// Depends on chmb_pkg, chmb_front, chmb_back, chmb_ram.
module color_histogram_model_backproject_top #(
  parameter int unsigned BIN_SHIFT        = 3,
  parameter int unsigned SAMPLE_FRAC_BITS = 0,
  parameter int unsigned COORD_BITS       = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  chan_a,
  input  logic [7:0]  chan_b,
  input  logic [7:0]  chan_c,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] likelihood,
  output logic        commit_done,
  input  logic        cfg_we,
  input  logic [chmb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [chmb_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import chmb_pkg::*;

  localparam int unsigned BIN_BITS = 3 * (8 - BIN_SHIFT);

  logic color_mode, inside_mode;
  logic [11:0] rect_left, rect_top, rect_right, rect_bottom;
  logic [30:0] base_rate;
  logic [24:0] rate_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b1;
      inside_mode <= 1'b1;
      rect_left <= '0;
      rect_top <= '0;
      rect_right <= '0;
      rect_bottom <= '0;
      base_rate <= '0;
      rate_ratio <= 25'h100_0000;
    end else if (cfg_we) begin
      unique case (32'(cfg_index))
        REG_COLOR_MODE:  color_mode <= cfg_data[0];
        REG_INSIDE_MODE: inside_mode <= cfg_data[0];
        REG_RECT_LEFT:   rect_left <= cfg_data[11:0];
        REG_RECT_TOP:    rect_top <= cfg_data[11:0];
        REG_RECT_RIGHT:  rect_right <= cfg_data[11:0];
        REG_RECT_BOTTOM: rect_bottom <= cfg_data[11:0];
        REG_BASE_RATE:   base_rate <= cfg_data;
        REG_RATE_RATIO:  rate_ratio <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  logic q_valid, q_pop, f_full, back_ready;
  cmd_t q_cmd;
  logic [BIN_BITS-1:0] q_bin;

  // hold off input until the back part has cleared its stores
  assign full = f_full || !back_ready;

  chmb_front #(
    .BIN_SHIFT(BIN_SHIFT), .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS),
    .COORD_BITS(COORD_BITS), .BIN_BITS(BIN_BITS)
  ) u_front (
    .clk, .rst,
    .in_push(push && back_ready), .in_full(f_full), .in_cmd(cmd_t'(cmd)),
    .in_x(pos_x), .in_y(pos_y), .in_a(chan_a), .in_b(chan_b), .in_c(chan_c),
    .color_mode, .inside_mode, .rect_left, .rect_top, .rect_right, .rect_bottom,
    .q_valid, .q_pop, .q_cmd, .q_bin
  );

  chmb_back #(.BIN_BITS(BIN_BITS)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .q_bin, .base_rate, .rate_ratio,
    .empty, .pop, .likelihood, .commit_done, .ready(back_ready)
  );
endmodule

/* design/chmb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chmb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/chmb_front.sv */
// Front part: rectangle test and binning, pushes classified items to a queue.
// Depends on chmb_pkg.
module chmb_front #(
  parameter int unsigned BIN_SHIFT        = 3,
  parameter int unsigned SAMPLE_FRAC_BITS = 0,
  parameter int unsigned COORD_BITS       = 12,
  parameter int unsigned BIN_BITS         = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_push,
  output logic                  in_full,
  input  chmb_pkg::cmd_t        in_cmd,
  input  logic [11:0]           in_x,
  input  logic [11:0]           in_y,
  input  logic [7:0]            in_a,
  input  logic [7:0]            in_b,
  input  logic [7:0]            in_c,
  input  logic                  color_mode,
  input  logic                  inside_mode,
  input  logic [11:0]           rect_left,
  input  logic [11:0]           rect_top,
  input  logic [11:0]           rect_right,
  input  logic [11:0]           rect_bottom,
  output logic                  q_valid,
  input  logic                  q_pop,
  output chmb_pkg::cmd_t        q_cmd,
  output logic [BIN_BITS-1:0]   q_bin
);
  import chmb_pkg::*;

  localparam int unsigned LVL   = 8 - BIN_SHIFT;
  localparam int unsigned SHIFT = SAMPLE_FRAC_BITS + BIN_SHIFT;
  localparam int unsigned CB    = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int unsigned QD    = 4;

  logic [LVL-1:0] qa, qb, qc;
  logic [BIN_BITS-1:0] bin;
  logic in_rect, keep;
  logic [CB-1:0] mx, my;

  assign qa = LVL'(in_a >> SHIFT);
  assign qb = LVL'(in_b >> SHIFT);
  assign qc = LVL'(in_c >> SHIFT);
  assign bin = color_mode ? BIN_BITS'({qa, qb, qc}) : BIN_BITS'(qa);
  assign mx = in_x[CB-1:0];
  assign my = in_y[CB-1:0];
  assign in_rect = (mx >= rect_left[CB-1:0]) && (mx < rect_right[CB-1:0]) &&
                   (my >= rect_top[CB-1:0]) && (my < rect_bottom[CB-1:0]);

  // drop learn pixels whose rectangle test does not match inside_mode, and unused commands
  always_comb begin
    unique case (in_cmd) inside
      CMD_LEARN:             keep = (in_rect == inside_mode);
      CMD_COMMIT, CMD_BPROJ: keep = 1'b1;
      default:               keep = 1'b0;
    endcase
  end

  cmd_t             fq_cmd [QD];
  logic [BIN_BITS-1:0] fq_bin [QD];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic push_ok, wr;

  assign in_full = (cnt == 3'(QD));
  assign push_ok = in_push && !in_full;
  assign wr = push_ok && keep;
  assign q_valid = (cnt != 3'd0);
  assign q_cmd = fq_cmd[rp];
  assign q_bin = fq_bin[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      fq_cmd[wp] <= in_cmd;
      fq_bin[wp] <= bin;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (q_pop && q_valid) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(q_pop && q_valid);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    in_full |-> !wr) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid || cnt == 3'd0) else $error("bad pop");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(QD)) else $error("count out of range");
endmodule

/* design/chmb_back.sv */
// Back part: frame accumulate, back-project read, commit sweep, clear pass.
// Depends on chmb_pkg and chmb_ram.
module chmb_back #(
  parameter int unsigned BIN_BITS = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  chmb_pkg::cmd_t      q_cmd,
  input  logic [BIN_BITS-1:0] q_bin,
  input  logic [30:0]         base_rate,
  input  logic [24:0]         rate_ratio,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         likelihood,
  output logic                commit_done,
  output logic                ready
);
  import chmb_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_RATE  = 6'b010000,
    S_SWEEP = 6'b100000
  } state_t;

  localparam logic [BIN_BITS-1:0] LAST = '1;

  state_t state;
  cmd_t cur_cmd;
  logic [BIN_BITS-1:0] cur_bin;
  logic [BIN_BITS:0] sw_rd;
  logic loaded;

  logic m_we, f_we;
  logic [BIN_BITS-1:0] m_wa, f_wa, m_ra, f_ra;
  logic [31:0] m_wd, f_wd, m_rd, f_rd;

  chmb_ram #(.WIDTH(32), .DEPTH(2**BIN_BITS)) u_model (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  chmb_ram #(.WIDTH(32), .DEPTH(2**BIN_BITS)) u_frame (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  // output register
  logic out_valid;
  logic [31:0] out_lh;
  logic out_cd;
  assign empty = !out_valid;
  assign likelihood = out_lh;
  assign commit_done = out_cd;
  assign ready = (state != S_CLEAR);

  // learning rate, registered
  logic [55:0] prod;
  logic [30:0] lr, keep;
  assign prod = 56'(base_rate) * 56'(rate_ratio);

  // blend pipeline: RAM read, stage 1 registers the reads, stage 2 the products
  logic rd_v, p1_v, p2_v;
  logic [BIN_BITS-1:0] rd_a, p1_a, p2_a;
  logic [31:0] p1_m, p1_f;
  logic [62:0] pm, pf;
  logic [63:0] acc;
  assign acc = 64'(pm) + 64'(pf);

  logic sweep_in;
  assign sweep_in = (state == S_SWEEP) && !sw_rd[BIN_BITS];

  assign q_pop = (state == S_IDLE) && q_valid &&
                 !(q_cmd != CMD_LEARN && out_valid);

  always_comb begin
    m_ra = q_bin;
    f_ra = q_bin;
    if (state == S_SWEEP) begin
      m_ra = sw_rd[BIN_BITS-1:0];
      f_ra = sw_rd[BIN_BITS-1:0];
    end else if (state != S_IDLE) begin
      m_ra = cur_bin;
      f_ra = cur_bin;
    end
    m_we = 1'b0;
    m_wa = p2_a;
    m_wd = loaded ? acc[61:30] : pf[31:0];
    f_we = 1'b0;
    f_wa = cur_bin;
    f_wd = (f_rd > 32'hFFFF_FFFF - 32'(Q8_ONE)) ? 32'hFFFF_FFFF : f_rd + 32'(Q8_ONE);
    unique case (state)
      S_CLEAR: begin
        f_we = 1'b1;
        f_wa = sw_rd[BIN_BITS-1:0];
        f_wd = '0;
        m_we = 1'b1;
        m_wa = sw_rd[BIN_BITS-1:0];
        m_wd = '0;
      end
      S_WR: f_we = (cur_cmd == CMD_LEARN);
      S_SWEEP: begin
        m_we = p2_v;
        f_we = p2_v;
        f_wa = p2_a;
        f_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd <= q_cmd;
      cur_bin <= q_bin;
    end
    if (state == S_RATE) begin
      lr <= (prod[55:24] > 32'(Q30_ONE)) ? Q30_ONE : prod[54:24];
    end
    keep <= Q30_ONE - lr;
    rd_a <= sw_rd[BIN_BITS-1:0];
    p1_a <= rd_a;
    p1_m <= m_rd;
    p1_f <= f_rd;
    p2_a <= p1_a;
    pm <= 63'(p1_m) * 63'(keep);
    // first commit copies the frame, kept in the low bits
    pf <= loaded ? 63'(p1_f) * 63'(lr) : 63'(p1_f);
    if (rst) begin
      state <= S_CLEAR;
      sw_rd <= '0;
      loaded <= 1'b0;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      rd_v <= sweep_in;
      p1_v <= rd_v;
      p2_v <= p1_v;
      unique case (state)
        S_CLEAR: begin
          sw_rd <= sw_rd + 1'b1;
          if (sw_rd[BIN_BITS-1:0] == LAST) state <= S_IDLE;
        end
        S_IDLE: if (q_pop) state <= (q_cmd == CMD_COMMIT) ? S_RATE : S_RD;
        S_RD: state <= S_WR;
        S_WR: begin
          if (cur_cmd == CMD_BPROJ) begin
            out_valid <= 1'b1;
            out_lh <= m_rd;
            out_cd <= 1'b0;
          end
          state <= S_IDLE;
        end
        S_RATE: begin
          sw_rd <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          // read address leads; the valid flag rides with the data through three stages
          if (sweep_in) sw_rd <= sw_rd + 1'b1;
          if (p2_v && p2_a == LAST) begin
            loaded <= 1'b1;
            out_valid <= 1'b1;
            out_lh <= '0;
            out_cd <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop outside idle");
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid) else $error("result lost");
endmodule
